// File: rtl/core/two_class_priority_queue_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the two-class priority queue
// Concurrent checks that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef TWO_CLASS_PRIORITY_QUEUE_TOP_ASSERT_SVH
`define TWO_CLASS_PRIORITY_QUEUE_TOP_ASSERT_SVH

`ifndef SYNTHESIS
`define TCPQ_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("two_class_priority_queue: assertion failed");
`define TCPQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("two_class_priority_queue: assertion failed");
`else
`define TCPQ_ASSERT(label, clk, rst, prop)
`define TCPQ_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// File: rtl/core/tcpq_pkg.sv
// ----------------------------------------------------------------------------
// tcpq_pkg
// Sizes, command codes and sequencer states of the two-class priority queue.
// ----------------------------------------------------------------------------
package tcpq_pkg;

   localparam int DEPTH   = 16;
   localparam int ID_BITS = 16;
   localparam int IDX_W   = $clog2(DEPTH);
   localparam int CNT_W   = $clog2(DEPTH + 1);
   localparam int ENTRY_W = ID_BITS + 1;

   typedef enum logic [1:0] {
      CMD_INSERT     = 2'd0,
      CMD_WITHDRAW   = 2'd1,
      CMD_SERVE_GEN  = 2'd2,
      CMD_SERVE_PREF = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_COMPACT,
      ST_FINISH
   } state_type;

endpackage

// File: rtl/core/tcpq_ram.sv
// ----------------------------------------------------------------------------
// tcpq_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module tcpq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/core/two_class_priority_queue_top.sv
// ----------------------------------------------------------------------------
// two_class_priority_queue_top
// Arrival-ordered table of unique IDs with a preferential class: insert,
// withdraw, serve oldest and serve oldest preferential, one result each.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake              Payload
//   req      in         req_valid / req_ready  cmd, person_id, is_preferential
//   rsp      out        rsp_valid / rsp_ready  ok, served_id, total_count,
//                                              pref_count
//
// An empty table, or an insert into a full one, skips the search; otherwise the
// table sits in one RAM with a single read port, so the ID search and the
// gap-closing shift each walk one entry per cycle.
// Reset clears the counts and the control state; the table contents are left
// as they are, since only entries below the count are ever used.
// A finished result waits in the last step until the output register is free.
//
`include "two_class_priority_queue_top_assert.svh"

module two_class_priority_queue_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_cmd,
   input  logic [15:0] req_person_id,
   input  logic        req_is_preferential,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_ok,
   output logic [15:0] rsp_served_id,
   output logic [4:0]  rsp_total_count,
   output logic [4:0]  rsp_pref_count
);

   import tcpq_pkg::*;

   state_type            state_ff, state_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [CNT_W-1:0]     pref_ff, pref_in;
   logic [CNT_W-1:0]     scan_ff, scan_in;
   cmd_type              cmd_ff, cmd_in;
   logic [ID_BITS-1:0]   id_ff, id_in;
   logic                 flag_ff, flag_in;
   logic                 ok_ff, ok_in;
   logic [ID_BITS-1:0]   served_ff, served_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_ok_ff, rsp_ok_in;
   logic [15:0]          rsp_served_ff, rsp_served_in;
   logic [4:0]           rsp_total_ff, rsp_total_in;
   logic [4:0]           rsp_pref_ff, rsp_pref_in;

   logic                 ram_we;
   logic [IDX_W-1:0]     ram_waddr;
   logic [ENTRY_W-1:0]   ram_wdata;
   logic [IDX_W-1:0]     ram_raddr;
   logic [ENTRY_W-1:0]   ram_rdata;

   logic                 fin_fire;
   logic                 insert_done;
   logic                 accept;

   tcpq_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign req_ready   = (state_ff == ST_IDLE);
   assign accept      = req_valid && req_ready;
   assign fin_fire    = (state_ff == ST_FINISH) && (!rsp_valid_ff || rsp_ready);
   assign insert_done = fin_fire && ok_ff && (cmd_ff == CMD_INSERT);

   always_comb begin
      logic [31:0]        req_id_wide;
      logic [31:0]        served_wide;
      logic [31:0]        total_wide;
      logic [31:0]        pref_wide;
      logic [CNT_W-1:0]   scan_p1;
      logic [CNT_W-1:0]   scan_p2;
      logic [ID_BITS-1:0] entry_id;
      logic               entry_pref;
      logic               match;
      logic               is_serve;

      req_id_wide = 32'(req_person_id);
      scan_p1     = scan_ff + CNT_W'(1);
      scan_p2     = scan_ff + CNT_W'(2);
      entry_id    = ram_rdata[ID_BITS-1:0];
      entry_pref  = ram_rdata[ID_BITS];
      is_serve    = cmd_ff inside {CMD_SERVE_GEN, CMD_SERVE_PREF};

      case (cmd_ff)
         CMD_INSERT:     match = (entry_id == id_ff);
         CMD_WITHDRAW:   match = (entry_id == id_ff);
         CMD_SERVE_GEN:  match = 1'b1;
         CMD_SERVE_PREF: match = entry_pref || (pref_ff == '0);
         default:        match = 1'b0;
      endcase

      state_in      = state_ff;
      count_in      = count_ff;
      pref_in       = pref_ff;
      scan_in       = scan_ff;
      cmd_in        = cmd_ff;
      id_in         = id_ff;
      flag_in       = flag_ff;
      ok_in         = ok_ff;
      served_in     = served_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_ok_in     = rsp_ok_ff;
      rsp_served_in = rsp_served_ff;
      rsp_total_in  = rsp_total_ff;
      rsp_pref_in   = rsp_pref_ff;
      ram_we        = 1'b0;
      ram_waddr     = scan_ff[IDX_W-1:0];
      ram_wdata     = ram_rdata;
      ram_raddr     = '0;
      served_wide   = '0;
      total_wide    = '0;
      pref_wide     = '0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd_in    = cmd_type'(req_cmd);
               id_in     = req_id_wide[ID_BITS-1:0];
               flag_in   = req_is_preferential;
               served_in = '0;
               scan_in   = '0;
               ok_in     = 1'b0;
               if (count_ff == '0) begin
                  // Nothing to search: an insert simply succeeds.
                  ok_in    = (cmd_type'(req_cmd) == CMD_INSERT);
                  state_in = ST_FINISH;
               end else if (cmd_type'(req_cmd) == CMD_INSERT &&
                            count_ff == CNT_W'(DEPTH)) begin
                  state_in = ST_FINISH;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (match) begin
               if (cmd_ff == CMD_INSERT) begin
                  ok_in    = 1'b0;
                  state_in = ST_FINISH;
               end else begin
                  ok_in     = 1'b1;
                  flag_in   = entry_pref;
                  served_in = is_serve ? entry_id : '0;
                  ram_raddr = scan_p1[IDX_W-1:0];
                  state_in  = ST_COMPACT;
               end
            end else if (scan_p1 == count_ff) begin
               ok_in    = (cmd_ff == CMD_INSERT);
               state_in = ST_FINISH;
            end else begin
               scan_in   = scan_p1;
               ram_raddr = scan_p1[IDX_W-1:0];
            end
         end
         ST_COMPACT: begin
            // Move the entry after the gap down by one slot per cycle.
            if (scan_p1 < count_ff) begin
               ram_we    = 1'b1;
               ram_waddr = scan_ff[IDX_W-1:0];
               ram_wdata = ram_rdata;
               ram_raddr = scan_p2[IDX_W-1:0];
               scan_in   = scan_p1;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (fin_fire) begin
               if (insert_done) begin
                  ram_we    = 1'b1;
                  ram_waddr = count_ff[IDX_W-1:0];
                  ram_wdata = {flag_ff, id_ff};
                  count_in  = count_ff + CNT_W'(1);
                  pref_in   = pref_ff + CNT_W'(flag_ff);
               end else if (ok_ff) begin
                  count_in = count_ff - CNT_W'(1);
                  pref_in  = pref_ff - CNT_W'(flag_ff);
               end
               served_wide   = 32'(served_ff);
               total_wide    = 32'(count_in);
               pref_wide     = 32'(pref_in);
               rsp_valid_in  = 1'b1;
               rsp_ok_in     = ok_ff;
               rsp_served_in = served_wide[15:0];
               rsp_total_in  = total_wide[4:0];
               rsp_pref_in   = pref_wide[4:0];
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         pref_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pref_ff      <= pref_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_ff       <= scan_in;
      cmd_ff        <= cmd_in;
      id_ff         <= id_in;
      flag_ff       <= flag_in;
      ok_ff         <= ok_in;
      served_ff     <= served_in;
      rsp_ok_ff     <= rsp_ok_in;
      rsp_served_ff <= rsp_served_in;
      rsp_total_ff  <= rsp_total_in;
      rsp_pref_ff   <= rsp_pref_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_ok          = rsp_ok_ff;
   assign rsp_served_id   = rsp_served_ff;
   assign rsp_total_count = rsp_total_ff;
   assign rsp_pref_count  = rsp_pref_ff;

   `TCPQ_ASSERT(a_pref_within_total, clock, reset, pref_ff <= count_ff)
   `TCPQ_ASSERT(a_count_bounded, clock, reset, count_ff <= CNT_W'(DEPTH))
   `TCPQ_ASSERT_NEXT(a_busy_after_accept, clock, reset, accept, !req_ready)
   `TCPQ_ASSERT_NEXT(a_insert_grows, clock, reset, insert_done, count_ff == $past(count_ff) + 1'b1)
   `TCPQ_ASSERT(a_served_implies_ok, clock, reset, !(rsp_valid_ff && rsp_served_ff != '0) || rsp_ok_ff)

endmodule

// File: dv/two_class_priority_queue_top_test.sv
// ----------------------------------------------------------------------------
// Testbench for the two-class priority queue
// Drives insert, withdraw and both serve commands through the request channel.
// A shadow waiting line in the testbench predicts every response, and each
// response is checked field by field. Both channels idle at random. The
// receiver also holds off once for a long stretch so that the queue backs up.
// ----------------------------------------------------------------------------
module two_class_priority_queue_top_test;

   import tcpq_pkg::*;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = DEPTH + 12;
   localparam int LONG_HOLD    = 300;
   localparam int POOL_SIZE    = 24;

   typedef struct {
      cmd_type            cmd;
      logic [ID_BITS-1:0] id;
      logic               pref;
   } command_type;

   typedef struct {
      logic [ID_BITS-1:0] id;
      logic               pref;
   } waiting_entry_type;

   typedef struct {
      logic               ok;
      logic [15:0]        served_id;
      logic [CNT_W-1:0]   total;
      logic [CNT_W-1:0]   pref;
   } outcome_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_cmd = CMD_INSERT;
   logic [15:0] req_person_id = '0;
   logic        req_is_preferential = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_ok;
   logic [15:0] rsp_served_id;
   logic [4:0]  rsp_total_count;
   logic [4:0]  rsp_pref_count;

   command_type       commands_to_send[$];
   waiting_entry_type waiting_line[$];
   int                waiting_pref = 0;
   outcome_type       awaited_outcomes[$];

   int mismatch_count  = 0;
   int cycle_count     = 0;
   int holds_requested = 0;

   two_class_priority_queue_top DUT (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_cmd             (req_cmd),
      .req_person_id       (req_person_id),
      .req_is_preferential (req_is_preferential),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_ok              (rsp_ok),
      .rsp_served_id       (rsp_served_id),
      .rsp_total_count     (rsp_total_count),
      .rsp_pref_count      (rsp_pref_count)
   );

   always #6 clock = ~clock;

   task automatic report_mismatch(input string what);
      $display("MISMATCH at cycle %0d: %s", cycle_count, what);
      mismatch_count++;
   endtask

   task automatic queue_command(input cmd_type cmd, input logic [ID_BITS-1:0] id,
                                input logic pref);
      command_type c;
      c.cmd  = cmd;
      c.id   = id;
      c.pref = pref;
      commands_to_send.push_back(c);
   endtask

   // Applies one accepted command to the shadow waiting line and records
   // the response it should produce.
   task automatic track_command(input cmd_type cmd, input logic [ID_BITS-1:0] id,
                                input logic pref);
      outcome_type o;
      int          pos;
      o.ok        = 1'b0;
      o.served_id = '0;
      pos         = -1;
      foreach (waiting_line[i]) begin
         if (pos < 0 && waiting_line[i].id == id) pos = i;
      end
      case (cmd)
         CMD_INSERT: begin
            if (waiting_line.size() < DEPTH && pos < 0) begin
               waiting_line.push_back('{id: id, pref: pref});
               if (pref) waiting_pref++;
               o.ok = 1'b1;
            end
         end
         CMD_WITHDRAW: begin
            if (pos >= 0) begin
               if (waiting_line[pos].pref) waiting_pref--;
               waiting_line.delete(pos);
               o.ok = 1'b1;
            end
         end
         default: begin
            if (waiting_line.size() > 0) begin
               pos = 0;
               // Preferential serve falls back to the oldest entry when no
               // preferential entry is waiting.
               if (cmd == CMD_SERVE_PREF) begin
                  for (int i = waiting_line.size() - 1; i >= 0; i--) begin
                     if (waiting_line[i].pref) pos = i;
                  end
               end
               o.served_id = waiting_line[pos].id;
               if (waiting_line[pos].pref) waiting_pref--;
               waiting_line.delete(pos);
               o.ok = 1'b1;
            end
         end
      endcase
      o.total = CNT_W'(waiting_line.size());
      o.pref  = CNT_W'(waiting_pref);
      awaited_outcomes.push_back(o);
   endtask

   // Each phase has its own mix of commands and its own pool of IDs, so that
   // duplicates and withdraw hits are common and the table reaches full.
   task automatic queue_random_phase(input int count);
      logic [ID_BITS-1:0] pool[POOL_SIZE];
      int                 mode;
      int                 pref_pct;
      int                 ins_pct;
      int                 wdr_pct;
      int                 roll;
      logic [ID_BITS-1:0] id;
      cmd_type            cmd;
      mode = $urandom_range(0, 2);
      case ($urandom_range(0, 2))
         0:       pref_pct = 0;
         1:       pref_pct = 30;
         default: pref_pct = 75;
      endcase
      ins_pct = (mode == 0) ? 70 : (mode == 1) ? 25 : 45;
      wdr_pct = (mode == 0) ? 10 : (mode == 1) ? 25 : 20;
      foreach (pool[i]) pool[i] = ID_BITS'($urandom);
      repeat (count) begin
         roll = $urandom_range(0, 99);
         if (roll < ins_pct) cmd = CMD_INSERT;
         else if (roll < ins_pct + wdr_pct) cmd = CMD_WITHDRAW;
         else if ($urandom_range(0, 1) == 0) cmd = CMD_SERVE_GEN;
         else cmd = CMD_SERVE_PREF;
         if ($urandom_range(0, 99) < 85) id = pool[$urandom_range(0, POOL_SIZE - 1)];
         else id = ID_BITS'($urandom);
         queue_command(cmd, id, $urandom_range(0, 99) < pref_pct);
      end
   endtask

   // Sender: bursts of random length separated by random gaps.
   int burst_left = 0;
   int gap_left   = 0;

   always @(posedge clock) begin
      bit taken;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         taken = req_valid && req_ready;
         if (taken) begin
            track_command(cmd_type'(req_cmd), req_person_id, req_is_preferential);
            void'(commands_to_send.pop_front());
            if (burst_left > 0) burst_left--;
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 24);
               gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
            end
         end
         if (taken || !req_valid) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (commands_to_send.size() > 0) begin
               req_valid           <= 1'b1;
               req_cmd             <= commands_to_send[0].cmd;
               req_person_id       <= commands_to_send[0].id;
               req_is_preferential <= commands_to_send[0].pref;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver: stall rate changes every so often; a requested long hold-off
   // keeps ready low for a fixed stretch so that the block backs up.
   int holds_done   = 0;
   int hold_left    = 0;
   int stall_pct    = 0;
   int stall_period = 0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (stall_period == 0) begin
            stall_period = $urandom_range(20, 80);
            case ($urandom_range(0, 4))
               0, 1:    stall_pct = 0;
               2:       stall_pct = 25;
               3:       stall_pct = 50;
               default: stall_pct = 85;
            endcase
         end
         stall_period--;
         if (hold_left == 0 && holds_done != holds_requested) begin
            holds_done = holds_requested;
            hold_left  = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= stall_pct);
         end
      end
   end

   // Monitor: every accepted response is compared with the oldest prediction.
   always @(posedge clock) begin
      outcome_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (awaited_outcomes.size() == 0) begin
            report_mismatch("response with no transaction outstanding");
         end else begin
            want = awaited_outcomes.pop_front();
            if (rsp_ok !== want.ok)
               report_mismatch($sformatf("ok %b, expected %b", rsp_ok, want.ok));
            if (rsp_served_id !== want.served_id)
               report_mismatch($sformatf("served_id %h, expected %h",
                                         rsp_served_id, want.served_id));
            if (rsp_total_count !== want.total)
               report_mismatch($sformatf("total_count %0d, expected %0d",
                                         rsp_total_count, want.total));
            if (rsp_pref_count !== want.pref)
               report_mismatch($sformatf("pref_count %0d, expected %0d",
                                         rsp_pref_count, want.pref));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timed out with %0d responses outstanding", awaited_outcomes.size());
         $display("== FAIL ==");
         $finish;
      end
   end

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Empty table: both serves and a withdraw fail.
      queue_command(CMD_SERVE_GEN, 16'h0000, 1'b0);
      queue_command(CMD_SERVE_PREF, 16'hFFFF, 1'b1);
      queue_command(CMD_WITHDRAW, 16'h0005, 1'b0);
      queue_command(CMD_INSERT, 16'h0000, 1'b0);
      queue_command(CMD_INSERT, 16'hFFFF, 1'b1);
      // Duplicate ID is refused.
      queue_command(CMD_INSERT, 16'h0000, 1'b1);
      for (int i = 1; i <= DEPTH - 2; i++)
         queue_command(CMD_INSERT, ID_BITS'(16'h0101 * i), i[0]);
      // The table is now full.
      queue_command(CMD_INSERT, 16'h1234, 1'b0);
      queue_command(CMD_SERVE_PREF, 16'h5A5A, 1'b0);
      queue_command(CMD_WITHDRAW, 16'h0000, 1'b1);
      queue_command(CMD_SERVE_GEN, 16'hA5A5, 1'b1);
      queue_command(CMD_WITHDRAW, 16'hFFFF, 1'b0);

      // The test waits here until every response has come back.
      while (commands_to_send.size() > 0 || awaited_outcomes.size() > 0)
         @(posedge clock);

      holds_requested++;
      repeat (8) queue_random_phase(40);
      while (commands_to_send.size() > 0 || awaited_outcomes.size() > 0)
         @(posedge clock);
      repeat (8) queue_random_phase(40);

      while (commands_to_send.size() > 0 || awaited_outcomes.size() > 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && awaited_outcomes.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

// File: sim.f
+incdir+rtl/core
rtl/core/tcpq_pkg.sv
rtl/core/tcpq_ram.sv
rtl/core/two_class_priority_queue_top.sv
dv/two_class_priority_queue_top_test.sv
